@@ rtl/core/jeo_pkg.sv @@
package jeo_pkg;

   // Field widths of the request and response transfers.
   localparam int PERSON_W = 7;
   localparam int STEP_W = 10;

   typedef logic [PERSON_W-1:0] person_type;
   typedef logic [STEP_W-1:0] step_type;

endpackage

@@ rtl/core/jeo_req_if.sv @@
interface jeo_req_if import jeo_pkg::*; ();

   logic       valid;
   logic       ready;
   person_type people_count;
   person_type start_person;
   step_type   step_count;

   modport source (output valid, output people_count, output start_person,
                   output step_count, input ready);
   modport sink (input valid, input people_count, input start_person,
                 input step_count, output ready);

endinterface

interface jeo_rsp_if import jeo_pkg::*; ();

   logic       valid;
   logic       ready;
   person_type person;
   logic       last;
   logic       bad_start;

   modport source (output valid, output person, output last, output bad_start,
                   input ready);
   modport sink (input valid, input person, input last, input bad_start,
                 output ready);

endinterface

@@ rtl/core/josephus_elimination_order.sv @@
// Josephus elimination order. Each request transfer poses one problem: people_count
// people in a ring, counting from start_person, every step_count-th person leaves.
// One response transfer is sent per person leaving, in order, the final one with
// last set; a start of zero or beyond the (saturated) people count gives a single
// response with person 0, last 1 and bad_start 1. The ring lives in a single-port
// link memory with a registered read, and each count costs one read and one use
// of a link; a problem waits whenever the response side stalls. A new request is
// taken only after the final response of the previous problem has been registered
// for output.
module josephus_elimination_order import jeo_pkg::*; #(
   parameter int MAX_PEOPLE = 64,
   parameter int MAX_STEP = 1023
) (
   input  logic       clock,
   input  logic       reset,
   jeo_req_if.sink    req,
   jeo_rsp_if.source  rsp
);

   localparam int IDXW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
   localparam int CW = (IDXW >= PERSON_W) ? IDXW + 1 : PERSON_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ERR   = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_ISSUE = 3'd3;
   localparam logic [2:0] S_USE   = 3'd4;

   logic [2:0]      state_ff, state_in;
   person_type      count_ff, count_in;
   step_type        step_ff, step_in;
   person_type      remaining_ff, remaining_in;
   step_type        progress_ff, progress_in;
   logic [IDXW-1:0] cur_ff, cur_in;
   logic [IDXW-1:0] prev_ff, prev_in;
   logic [IDXW-1:0] init_idx_ff, init_idx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   person_type      rsp_person_ff, rsp_person_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_bad_ff, rsp_bad_in;

   logic [IDXW-1:0] link_mem [MAX_PEOPLE];
   logic [IDXW-1:0] link_rd_ff;
   logic            rd_en;
   logic            wr_en;
   logic [IDXW-1:0] wr_addr;
   logic [IDXW-1:0] wr_data;

   person_type      n_eff;
   step_type        s_eff;
   logic            bad;
   logic            slot_free;
   logic            emit;
   logic            init_done;

   // Saturate the request fields and check the start person.
   always_comb begin
      if (CW'(req.people_count) > CW'(MAX_PEOPLE)) begin
         n_eff = PERSON_W'(MAX_PEOPLE);
      end else begin
         n_eff = req.people_count;
      end
      if (req.step_count == '0) begin
         s_eff = STEP_W'(1);
      end else if (32'(req.step_count) > 32'(MAX_STEP)) begin
         s_eff = STEP_W'(MAX_STEP);
      end else begin
         s_eff = req.step_count;
      end
      bad = (n_eff == '0) || (req.start_person == '0) || (req.start_person > n_eff);
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign init_done = (CW'(init_idx_ff) + CW'(1)) == CW'(count_ff);
   assign req.ready = (state_ff == S_IDLE);

   // Sequencer: ring fill, then read and use of one link per count.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in = step_ff;
      remaining_in = remaining_ff;
      progress_in = progress_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      init_idx_in = init_idx_ff;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_addr = init_idx_ff;
      wr_data = init_done ? '0 : IDXW'(CW'(init_idx_ff) + CW'(1));
      emit = 1'b0;
      rsp_person_in = rsp_person_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in = rsp_bad_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               count_in = n_eff;
               step_in = s_eff;
               remaining_in = n_eff;
               progress_in = STEP_W'(1);
               cur_in = IDXW'(req.start_person - PERSON_W'(1));
               if (req.start_person == PERSON_W'(1)) begin
                  prev_in = IDXW'(n_eff - PERSON_W'(1));
               end else begin
                  prev_in = IDXW'(req.start_person - PERSON_W'(2));
               end
               init_idx_in = '0;
               state_in = bad ? S_ERR : S_INIT;
            end
         end
         S_ERR: begin
            if (slot_free) begin
               emit = 1'b1;
               rsp_person_in = '0;
               rsp_last_in = 1'b1;
               rsp_bad_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INIT: begin
            wr_en = 1'b1;
            init_idx_in = init_idx_ff + IDXW'(1);
            if (init_done) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (remaining_ff == PERSON_W'(1)) begin
               // The one left seated leaves without further counting.
               if (slot_free) begin
                  emit = 1'b1;
                  rsp_person_in = PERSON_W'(CW'(cur_ff) + CW'(1));
                  rsp_last_in = 1'b1;
                  rsp_bad_in = 1'b0;
                  remaining_in = '0;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en = 1'b1;
               state_in = S_USE;
            end
         end
         S_USE: begin
            if (progress_ff < step_ff) begin
               prev_in = cur_ff;
               cur_in = link_rd_ff;
               progress_in = progress_ff + STEP_W'(1);
               state_in = S_ISSUE;
            end else if (slot_free) begin
               // The counted person leaves and is unlinked from the ring.
               emit = 1'b1;
               rsp_person_in = PERSON_W'(CW'(cur_ff) + CW'(1));
               rsp_last_in = 1'b0;
               rsp_bad_in = 1'b0;
               wr_en = 1'b1;
               wr_addr = prev_ff;
               wr_data = link_rd_ff;
               cur_in = link_rd_ff;
               remaining_in = remaining_ff - PERSON_W'(1);
               progress_in = STEP_W'(1);
               state_in = S_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Link memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[cur_ff];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         remaining_ff <= '0;
         progress_ff <= '0;
         cur_ff <= '0;
         prev_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         remaining_ff <= remaining_in;
         progress_ff <= progress_in;
         cur_ff <= cur_in;
         prev_ff <= prev_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      step_ff <= step_in;
      init_idx_ff <= init_idx_in;
      rsp_person_ff <= rsp_person_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.person = rsp_person_ff;
   assign rsp.last = rsp_last_ff;
   assign rsp.bad_start = rsp_bad_ff;

   // An error response is always the final one and names nobody.
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_start |-> rsp.last && (rsp.person == '0))
      else $error("error response without last or with a person");

   // The ring is never written while the block is idle.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("link memory written while idle");

   // Someone is always seated while the ring is walked.
   a_ring_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE || state_ff == S_USE) |-> (remaining_ff != '0))
      else $error("ring walked with nobody seated");

   // The round count never passes the step.
   a_progress_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_USE) |-> (progress_ff <= step_ff))
      else $error("count passed the step");

endmodule
